// File: hdl/rar_pkg.sv
package rar_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_e;

  // handshake between the sequencer and the shared divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: hdl/rar_div.sv
module rar_div
  import rar_pkg::*;
#(
  parameter int W = 65
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o,
  output div_ctl_t     ctl_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // one restoring step per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d  = diff[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};

endmodule

// File: hdl/rational_arith_reduce.sv
// channel | direction | handshake          | beat fields
// in      | input     | in_valid/in_stall   | operation, a_num, a_den, b_num, b_den
// out     | output    | out_valid/out_stall | res_num, res_den, zero_den_error
//
// a beat passes ST_MUL, ST_SUM, ST_GCD (one divider pass per euclid remainder),
// ST_DIVN, ST_DIVD and ST_OUT; a zero numerator or zero denominator goes from
// ST_SUM straight to ST_OUT. the shared restoring divider (one quotient bit per
// cycle) is reused for every euclid remainder and both final divisions.
// reset clears the sequencer and the output valid; no clearing pass.
// in_stall is high from acceptance until the result beat is taken.
module rational_arith_reduce
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic signed [15:0] a_num_i,
  input  logic signed [15:0] a_den_i,
  input  logic signed [15:0] b_num_i,
  input  logic signed [15:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        zero_den_error_o
);

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int MW = PW + 1;
  localparam int XW = (MW > 64) ? MW : 64;

  state_e state_q, state_d;

  logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
  logic          ans_q, ads_q, bns_q, bds_q;
  op_e           op_q;
  logic [PW-1:0] p0_q, p1_q;
  logic          s0_q, s1_q, s2_q;
  logic [MW-1:0] nm_q, dm_q, gx_q, gy_q;
  logic          nneg_q, dneg_q;
  logic [MW-1:0] nred_q;
  logic signed [31:0] rnum_q;
  logic [30:0]   rden_q;
  logic          rerr_q;
  logic          ovalid_q;

  logic          dstart;
  logic [MW-1:0] ddvd, ddvs, dquo, drem;
  div_ctl_t      dctl;
  logic          accept;
  logic [OW-1:0] mx, my;
  logic [PW-1:0] prod;
  logic [OW-1:0] an_x, ad_x, bn_x, bd_x;
  logic [MW-1:0] nsum;
  logic          nsneg;
  logic [XW-1:0] nred_x, dquo_x;

  assign accept = in_valid_i && !in_stall_o;

  // magnitude of an operand sign-extended from OW bits
  function automatic logic [OW-1:0] mag_f(input logic [OW-1:0] v);
    logic [OW-1:0] r;
    r = v[OW-1] ? (~v + OW'(1)) : v;
    return r;
  endfunction

  function automatic logic [OW-1:0] opnd_f(input logic [15:0] v);
    logic [OW-1:0] r;
    r = OW'(signed'(v));
    return r;
  endfunction

  // operands taken at OW bits
  assign an_x = opnd_f(a_num_i);
  assign ad_x = opnd_f(a_den_i);
  assign bn_x = opnd_f(b_num_i);
  assign bd_x = opnd_f(b_den_i);

  rar_div #(.W(MW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dstart),
    .dividend_i(ddvd),
    .divisor_i (ddvs),
    .quot_o    (dquo),
    .rem_o     (drem),
    .ctl_o     (dctl)
  );

  // three products formed in the ST_MUL cycle
  always_comb begin
    unique case (op_q)
      OP_MUL:  begin mx = an_q; my = bn_q; end
      default: begin mx = an_q; my = bd_q; end
    endcase
  end
  assign prod = PW'(mx) * PW'(my);

  // signed sum of the cross products for add and subtract
  always_comb begin
    nsum  = nm_q;
    nsneg = s0_q;
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      if (s0_q == s1_q) begin
        nsum = MW'(p0_q) + MW'(p1_q); nsneg = s0_q;
      end else if (p0_q >= p1_q) begin
        nsum = MW'(p0_q - p1_q); nsneg = s0_q;
      end else begin
        nsum = MW'(p1_q - p0_q); nsneg = s1_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  begin
        if (dm_q == '0 || nsum == '0) state_d = ST_OUT;
        else state_d = ST_GCD;
      end
      ST_GCD:  if (gy_q == '0) state_d = ST_DIVN;
      ST_DIVN: if (dctl.done) state_d = ST_DIVD;
      ST_DIVD: if (dctl.done) state_d = ST_OUT;
      ST_OUT:  if (!ovalid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // divider control
  always_comb begin
    dstart = 1'b0;
    ddvd   = gx_q;
    ddvs   = gy_q;
    unique case (state_q)
      ST_GCD: dstart = (gy_q != '0) && !dctl.busy && !dctl.done;
      ST_DIVN: begin
        ddvd   = nm_q;
        ddvs   = gx_q;
        dstart = !dctl.busy && !dctl.done;
      end
      ST_DIVD: begin
        ddvd   = dm_q;
        ddvs   = gx_q;
        dstart = !dctl.busy && !dctl.done;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE) || ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && state_d == ST_IDLE) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept) begin
        op_q  <= op_e'(operation_i);
        an_q  <= mag_f(an_x);  ans_q <= an_x[OW-1];
        ad_q  <= mag_f(ad_x);  ads_q <= ad_x[OW-1];
        bn_q  <= mag_f(bn_x);  bns_q <= bn_x[OW-1];
        bd_q  <= mag_f(bd_x);  bds_q <= bd_x[OW-1];
      end
      ST_MUL: begin
        p0_q <= prod;
        s0_q <= (op_q == OP_MUL) ? (ans_q ^ bns_q) : (ans_q ^ bds_q);
        p1_q <= PW'(bn_q) * PW'(ad_q);
        s1_q <= bns_q ^ ads_q ^ (op_q == OP_SUB);
        s2_q <= (op_q == OP_DIV) ? (ads_q ^ bns_q) : (ads_q ^ bds_q);
        // product numerator for multiply and divide
        nm_q <= MW'(prod);
        dm_q <= (op_q == OP_DIV) ? MW'(PW'(ad_q) * PW'(bn_q))
                                 : MW'(PW'(ad_q) * PW'(bd_q));
      end
      ST_SUM: begin
        nm_q   <= nsum;
        nneg_q <= nsneg;
        dneg_q <= s2_q;
        gx_q   <= nsum;
        gy_q   <= dm_q;
      end
      ST_GCD: begin
        if (dctl.done) begin
          gx_q <= gy_q;
          gy_q <= drem;
        end
      end
      ST_DIVN: if (dctl.done) nred_q <= dquo;
      default: ;
    endcase
  end

  // widened copies for the saturation compares
  assign nred_x = XW'(nred_q);
  assign dquo_x = XW'(dquo);

  // saturation and packing of the result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      if (dm_q == '0) begin
        rnum_q <= '0; rden_q <= '0; rerr_q <= 1'b1;
      end else if (nsum == '0) begin
        rnum_q <= '0; rden_q <= 31'd1; rerr_q <= 1'b0;
      end else begin
        rerr_q <= 1'b0;
      end
    end else if (state_q == ST_DIVD && dctl.done) begin
      if (nneg_q ^ dneg_q) begin
        rnum_q <= (nred_x > XW'(64'h8000_0000)) ? 32'sh8000_0000
                                                : -signed'(nred_x[31:0]);
      end else begin
        rnum_q <= (nred_x > XW'(64'h7fff_ffff)) ? 32'sh7fff_ffff
                                                : signed'(nred_x[31:0]);
      end
      rden_q <= (dquo_x > XW'(64'h7fff_ffff)) ? 31'h7fff_ffff : dquo_x[30:0];
    end
  end

  assign out_valid_o      = ovalid_q;
  assign res_num_o        = rnum_q;
  assign res_den_o        = rden_q;
  assign zero_den_error_o = rerr_q;

endmodule

// File: hdl/rar_checker.sv
module rar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] res_num_o,
  input logic [30:0] res_den_o,
  input logic        zero_den_error_o
);

  // no new beat accepted while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open with result pending");

  // error beats carry 0/0
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_den_error_o |-> res_num_o == '0 && res_den_o == '0)
    else $error("error beat not 0/0");

  // good beats have a positive denominator
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_den_error_o |-> res_den_o != '0)
    else $error("zero denominator without error");

  // stalled result stays valid and its numerator holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_num_o))
    else $error("stalled result changed");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .res_num_o       (res_num_o),
  .res_den_o       (res_den_o),
  .zero_den_error_o(zero_den_error_o)
);
